// ===== rtl/core/wss_pkg.sv =====
// ----------------------------------------------------------------------------
// wss_pkg
// Shared types and constants of the waveset segmenter.
// ----------------------------------------------------------------------------
package wss_pkg;

    localparam int LEN_BITS = 24;

    typedef struct packed {
        logic full;
        logic empty;
    } wss_qstat_t;

endpackage

// ===== rtl/core/wss_front.sv =====
// ----------------------------------------------------------------------------
// wss_front
// Sample intake: squares each sample, tracks rising zero crossings and the
// open span, and hands every closed span to the job queue.
// ----------------------------------------------------------------------------
module wss_front
    import wss_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int POS_BITS    = 32,
    parameter int ACC_BITS    = 48,
    localparam int SQ_BITS    = 2 * SAMPLE_BITS,
    localparam int SUM_BITS   = (ACC_BITS > SQ_BITS) ? ACC_BITS : SQ_BITS,
    localparam int JOB_BITS   = 2 * POS_BITS + SUM_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic [LEN_BITS-1:0]    min_length,
    input  wss_qstat_t             qstat,
    output logic                   push,
    output logic [JOB_BITS-1:0]    job
);

    localparam int CMP_BITS = (POS_BITS > LEN_BITS) ? POS_BITS : LEN_BITS;
    localparam logic [SUM_BITS:0] ACC_MAX =
        {{(SUM_BITS + 1 - ACC_BITS){1'b0}}, {ACC_BITS{1'b1}}};

    logic                have_prev_reg,  have_prev_next;
    logic                prev_nonpos_reg, prev_nonpos_next;
    logic [POS_BITS-1:0] pos_reg,        pos_next;
    logic                cross_valid_reg, cross_valid_next;
    logic [POS_BITS-1:0] cross_pos_reg,  cross_pos_next;
    logic [SUM_BITS-1:0] sum_reg,        sum_next;

    logic                   accept;
    logic                   negative;
    logic                   positive;
    logic                   crossing;
    logic                   long_enough;
    logic [SAMPLE_BITS-1:0] mag;
    logic [SQ_BITS-1:0]     sq;
    logic [POS_BITS-1:0]    span_len;
    logic [SUM_BITS:0]      sum_wide;
    logic [SUM_BITS-1:0]    sum_sat;

    assign in_ready = !qstat.full;
    assign accept   = in_valid && in_ready;

    assign negative = sample[SAMPLE_BITS-1];
    assign positive = !negative && (sample != '0);
    assign mag      = negative ? (~sample + 1'b1) : sample;
    assign sq       = SQ_BITS'(mag) * SQ_BITS'(mag);
    assign crossing = have_prev_reg && prev_nonpos_reg && positive;

    assign span_len    = pos_reg - cross_pos_reg;
    assign long_enough = CMP_BITS'(span_len) > CMP_BITS'(min_length);

    assign sum_wide = {1'b0, sum_reg} + (SUM_BITS + 1)'(sq);
    assign sum_sat  = (sum_wide > ACC_MAX) ? ACC_MAX[SUM_BITS-1:0] : sum_wide[SUM_BITS-1:0];

    assign push = accept && crossing && cross_valid_reg && long_enough;
    assign job  = {cross_pos_reg, pos_reg, sum_reg};

    always_comb
    begin
        have_prev_next   = have_prev_reg;
        prev_nonpos_next = prev_nonpos_reg;
        pos_next         = pos_reg;
        cross_valid_next = cross_valid_reg;
        cross_pos_next   = cross_pos_reg;
        sum_next         = sum_reg;
        if (accept)
        begin
            have_prev_next   = 1'b1;
            prev_nonpos_next = !positive;
            pos_next         = pos_reg + 1'b1;
            if (crossing && !cross_valid_reg)
            begin
                cross_valid_next = 1'b1;
                cross_pos_next   = pos_reg;
                sum_next         = SUM_BITS'(sq);
            end
            else if (crossing && long_enough)
            begin
                cross_pos_next = pos_reg;
                sum_next       = SUM_BITS'(sq);
            end
            else
            begin
                sum_next = sum_sat;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_prev_reg   <= 1'b0;
            prev_nonpos_reg <= 1'b0;
            pos_reg         <= '0;
            cross_valid_reg <= 1'b0;
            cross_pos_reg   <= '0;
            sum_reg         <= '0;
        end
        else
        begin
            have_prev_reg   <= have_prev_next;
            prev_nonpos_reg <= prev_nonpos_next;
            pos_reg         <= pos_next;
            cross_valid_reg <= cross_valid_next;
            cross_pos_reg   <= cross_pos_next;
            sum_reg         <= sum_next;
        end
    end

endmodule

// ===== rtl/core/wss_queue.sv =====
// ----------------------------------------------------------------------------
// wss_queue
// Two-entry job queue between the sample intake and the RMS engine.
// ----------------------------------------------------------------------------
module wss_queue
    import wss_pkg::*;
#(
    parameter int WIDTH = 128
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output wss_qstat_t       qstat
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg,  count_next;
    logic             do_push;
    logic             do_pop;

    assign qstat.full  = (count_reg == 2'd2);
    assign qstat.empty = (count_reg == 2'd0);
    assign do_push     = push && !qstat.full;
    assign do_pop      = pop && !qstat.empty;
    assign rd_data     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== rtl/core/wss_back.sv =====
// ----------------------------------------------------------------------------
// wss_back
// RMS engine: restoring divide of the square sum by the span length, one
// quotient bit per cycle, then a digit-by-digit square root, one root bit
// per cycle, and an output register.
// ----------------------------------------------------------------------------
module wss_back
    import wss_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int POS_BITS    = 32,
    parameter int ACC_BITS    = 48,
    localparam int SQ_BITS    = 2 * SAMPLE_BITS,
    localparam int SUM_BITS   = (ACC_BITS > SQ_BITS) ? ACC_BITS : SQ_BITS,
    localparam int JOB_BITS   = 2 * POS_BITS + SUM_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  wss_qstat_t             qstat,
    input  logic [JOB_BITS-1:0]    job,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [POS_BITS-1:0]    start_pos,
    output logic [POS_BITS-1:0]    end_pos,
    output logic [SAMPLE_BITS-1:0] rms
);

    localparam int ROOT_BITS = (SUM_BITS + 1) / 2;
    localparam int VAL_BITS  = 2 * ROOT_BITS;
    localparam int CNT_BITS  = $clog2(SUM_BITS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_SQRT = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]             state_reg, state_next;
    logic [CNT_BITS-1:0]    cnt_reg,   cnt_next;
    logic [POS_BITS-1:0]    start_reg, start_next;
    logic [POS_BITS-1:0]    end_reg,   end_next;
    logic [POS_BITS-1:0]    div_reg,   div_next;
    logic [POS_BITS-1:0]    rem_reg,   rem_next;
    logic [SUM_BITS-1:0]    quot_reg,  quot_next;
    logic [VAL_BITS-1:0]    val_reg,   val_next;
    logic [ROOT_BITS-1:0]   root_reg,  root_next;
    logic [ROOT_BITS:0]     srem_reg,  srem_next;
    logic [SAMPLE_BITS-1:0] rms_reg,   rms_next;

    logic [POS_BITS:0]      rem_sh;
    logic                   div_ge;
    logic [SUM_BITS-1:0]    quot_step;
    logic [ROOT_BITS+2:0]   srem_sh;
    logic [ROOT_BITS+2:0]   trial;
    logic                   sqrt_ge;
    logic [ROOT_BITS-1:0]   root_step;

    assign rem_sh    = {rem_reg, quot_reg[SUM_BITS-1]};
    assign div_ge    = rem_sh >= {1'b0, div_reg};
    assign quot_step = {quot_reg[SUM_BITS-2:0], div_ge};

    assign srem_sh   = {srem_reg, val_reg[VAL_BITS-1 -: 2]};
    assign trial     = {1'b0, root_reg, 2'b01};
    assign sqrt_ge   = srem_sh >= trial;
    assign root_step = {root_reg[ROOT_BITS-2:0], sqrt_ge};

    assign pop       = (state_reg == ST_IDLE) && !qstat.empty;
    assign out_valid = (state_reg == ST_OUT);
    assign start_pos = start_reg;
    assign end_pos   = end_reg;
    assign rms       = rms_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        start_next = start_reg;
        end_next   = end_reg;
        div_next   = div_reg;
        rem_next   = rem_reg;
        quot_next  = quot_reg;
        val_next   = val_reg;
        root_next  = root_reg;
        srem_next  = srem_reg;
        rms_next   = rms_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!qstat.empty)
                begin
                    start_next = job[JOB_BITS-1 -: POS_BITS];
                    end_next   = job[SUM_BITS +: POS_BITS];
                    div_next   = job[SUM_BITS +: POS_BITS] - job[JOB_BITS-1 -: POS_BITS];
                    quot_next  = job[SUM_BITS-1:0];
                    rem_next   = '0;
                    cnt_next   = CNT_BITS'(SUM_BITS - 1);
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next  = div_ge ? POS_BITS'(rem_sh - {1'b0, div_reg}) : rem_sh[POS_BITS-1:0];
                quot_next = quot_step;
                if (cnt_reg == '0)
                begin
                    val_next   = VAL_BITS'(quot_step);
                    root_next  = '0;
                    srem_next  = '0;
                    cnt_next   = CNT_BITS'(ROOT_BITS - 1);
                    state_next = ST_SQRT;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_SQRT:
            begin
                srem_next = sqrt_ge ? (ROOT_BITS + 1)'(srem_sh - trial)
                                    : srem_sh[ROOT_BITS:0];
                root_next = root_step;
                val_next  = {val_reg[VAL_BITS-3:0], 2'b00};
                if (cnt_reg == '0)
                begin
                    rms_next   = root_step[SAMPLE_BITS-1:0];
                    state_next = ST_OUT;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg <= start_next;
        end_reg   <= end_next;
        div_reg   <= div_next;
        rem_reg   <= rem_next;
        quot_reg  <= quot_next;
        val_reg   <= val_next;
        root_reg  <= root_next;
        srem_reg  <= srem_next;
        rms_reg   <= rms_next;
    end

endmodule

// ===== rtl/core/waveset_segmenter_rms.sv =====
// Flow: the closing sample's span goes into the job queue; the RMS engine takes
//   it when idle, divides, takes the square root and holds the result until taken.
// Throughput: one sample per cycle while the two-entry job queue has room;
//   the serial divider and square-root unit finish each job before taking another.
// Reset: rst_n clears all span tracking, the job queue, the engine and
//   min_length; no results are pending after reset.
// ----------------------------------------------------------------------------
// waveset_segmenter_rms
// Splits an audio stream at rising zero crossings and reports each span
// longer than min_length with its position range and RMS level.
// ----------------------------------------------------------------------------
module waveset_segmenter_rms
    import wss_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int POS_BITS    = 32,
    parameter int ACC_BITS    = 48
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [LEN_BITS-1:0]    cfg_wr_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [SAMPLE_BITS-1:0] sample,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [POS_BITS-1:0]    start_pos,
    output logic [POS_BITS-1:0]    end_pos,
    output logic [SAMPLE_BITS-1:0] rms
);

    localparam int SQ_BITS  = 2 * SAMPLE_BITS;
    localparam int SUM_BITS = (ACC_BITS > SQ_BITS) ? ACC_BITS : SQ_BITS;
    localparam int JOB_BITS = 2 * POS_BITS + SUM_BITS;

    logic [LEN_BITS-1:0] min_length_reg;
    logic                push;
    logic                pop;
    logic [JOB_BITS-1:0] job_in;
    logic [JOB_BITS-1:0] job_out;
    wss_qstat_t          qstat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_length_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            min_length_reg <= cfg_wr_data;
        end
    end

    wss_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .POS_BITS    (POS_BITS),
        .ACC_BITS    (ACC_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .sample     (sample),
        .min_length (min_length_reg),
        .qstat      (qstat),
        .push       (push),
        .job        (job_in)
    );

    wss_queue #(
        .WIDTH (JOB_BITS)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (job_in),
        .pop     (pop),
        .rd_data (job_out),
        .qstat   (qstat)
    );

    wss_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .POS_BITS    (POS_BITS),
        .ACC_BITS    (ACC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .qstat     (qstat),
        .job       (job_out),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .start_pos (start_pos),
        .end_pos   (end_pos),
        .rms       (rms)
    );

endmodule

// ===== rtl/core/wss_checker.sv =====
// ----------------------------------------------------------------------------
// wss_checker
// Port-level checks of the waveset segmenter, bound to the top level.
// ----------------------------------------------------------------------------
module wss_checker
    import wss_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int POS_BITS    = 32
)
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   cfg_wr_en,
    input logic [LEN_BITS-1:0]    cfg_wr_data,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic [SAMPLE_BITS-1:0] sample,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [POS_BITS-1:0]    start_pos,
    input logic [POS_BITS-1:0]    end_pos,
    input logic [SAMPLE_BITS-1:0] rms
);

    localparam logic [SAMPLE_BITS-1:0] RMS_MAX = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(start_pos)
            && $stable(end_pos) && $stable(rms))
        else $error("result changed before transfer");

    a_rms_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> rms <= RMS_MAX)
        else $error("rms above full scale");

    a_span_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> end_pos != start_pos)
        else $error("empty span reported");

    a_one_per_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> !out_valid)
        else $error("result repeated after transfer");

endmodule

bind waveset_segmenter_rms wss_checker #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .POS_BITS    (POS_BITS)
) u_wss_checker (.*);

// ===== dv/waveset_span_checker.sv =====
// ----------------------------------------------------------------------------
// waveset_span_checker
// Watches the sample, configuration and span channels of the waveset
// segmenter, predicts each closed span with its RMS level, and compares
// every span transfer against the oldest predicted span.
// ----------------------------------------------------------------------------
module waveset_span_checker
    import wss_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [LEN_BITS-1:0] cfg_wr_data,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic [15:0]         sample,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic [31:0]         start_pos,
    input  logic [31:0]         end_pos,
    input  logic [15:0]         rms,
    output int                  mismatches,
    output int                  spans_due
);

    typedef struct packed {
        logic [31:0] first;
        logic [31:0] stop;
        logic [15:0] level;
    } span_t;

    span_t pending_spans[$];

    logic                seen_any;
    logic                prev_nonpos;
    logic [31:0]         next_pos;
    logic                span_open;
    logic [31:0]         span_start;
    logic [47:0]         sq_acc;
    logic [LEN_BITS-1:0] min_len;
    int                  errs = 0;

    function automatic logic [15:0] root_floor(input logic [47:0] v);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = 24; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= {16'd0, v})
                root = trial;
        end
        return root[15:0];
    endfunction

    function void absorb_sample(input logic [15:0] s);
        logic [16:0] mag;
        logic [47:0] sq;
        logic [48:0] sum_ext;
        logic [31:0] span_len;
        logic        positive;
        logic        rising;
        span_t       got;
        mag      = s[15] ? (17'h10000 - {1'b0, s}) : {1'b0, s};
        sq       = 48'(mag) * 48'(mag);
        positive = !s[15] && (s != 16'd0);
        rising   = seen_any && prev_nonpos && positive;
        sum_ext  = {1'b0, sq_acc} + {1'b0, sq};
        span_len = next_pos - span_start;
        if (rising && !span_open)
        begin
            span_open  = 1'b1;
            span_start = next_pos;
            sq_acc     = sq;
        end
        else if (rising && span_len > {8'd0, min_len})
        begin
            got.first  = span_start;
            got.stop   = next_pos;
            got.level  = root_floor(sq_acc / 48'(span_len));
            pending_spans.push_back(got);
            span_start = next_pos;
            sq_acc     = sq;
        end
        else
        begin
            sq_acc = sum_ext[48] ? '1 : sum_ext[47:0];
        end
        seen_any    = 1'b1;
        prev_nonpos = !positive;
        next_pos    = next_pos + 32'd1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        span_t want;
        if (!rst_n)
        begin
            seen_any    = 1'b0;
            prev_nonpos = 1'b0;
            next_pos    = '0;
            span_open   = 1'b0;
            span_start  = '0;
            sq_acc      = '0;
            min_len     = '0;
            pending_spans.delete();
        end
        else
        begin
            if (cfg_wr_en)
                min_len = cfg_wr_data;
            if (out_valid && out_ready)
            begin
                if (pending_spans.size() == 0)
                begin
                    errs++;
                    if (errs <= 10)
                        $display("unexpected span transfer: start=%0d end=%0d rms=%0d",
                                 start_pos, end_pos, rms);
                end
                else
                begin
                    want = pending_spans.pop_front();
                    if (want.first !== start_pos || want.stop !== end_pos
                        || want.level !== rms)
                    begin
                        errs++;
                        if (errs <= 10)
                            $display({"span mismatch: expected start=%0d end=%0d rms=%0d,",
                                      " got start=%0d end=%0d rms=%0d"},
                                     want.first, want.stop, want.level,
                                     start_pos, end_pos, rms);
                    end
                end
            end
            if (in_valid && in_ready)
                absorb_sample(sample);
        end
        mismatches <= errs;
        spans_due  <= pending_spans.size();
    end

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives the waveset segmenter with directed crossings, a long full-scale
// span and random waveform bursts under several min_length settings, with
// random gaps on the sample side and stalls on the span side; the checker
// does the prediction and this top gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
    import wss_pkg::*;

    localparam int CYCLE_LIMIT   = 3_000_000;
    localparam int SETTLE_CYCLES = 100;
    localparam int LONG_RUN      = 100;
    localparam int BURST_ITEMS   = 180;

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                cfg_wr_en   = 1'b0;
    logic [LEN_BITS-1:0] cfg_wr_data = '0;
    logic                in_valid    = 1'b0;
    logic                in_ready;
    logic [15:0]         sample      = '0;
    logic                out_valid;
    logic                out_ready   = 1'b0;
    logic [31:0]         start_pos;
    logic [31:0]         end_pos;
    logic [15:0]         rms;
    int                  mismatches;
    int                  spans_due;
    bit                  quiet       = 1'b0;
    int                  cur_min     = 0;

    logic [15:0]         opening [13] = '{16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000,
                                          16'h0001, 16'h0001, 16'h7FFF, 16'h8000,
                                          16'h7FFF, 16'h0000, 16'h0001, 16'hFFFB,
                                          16'h4000};
    logic [15:0]         growing [12] = '{16'hFFFF, 16'h0002, 16'hFFFF, 16'h0002,
                                          16'hFFFF, 16'h0002, 16'hFFFF, 16'h0002,
                                          16'h0000, 16'h0000, 16'h0000, 16'h0001};
    logic [LEN_BITS-1:0] phase_min [6] = '{24'd0, 24'hFFFFFF, 24'd1, 24'd12,
                                          24'd4, 24'd40};

    initial
    begin
        forever #6 clk = ~clk;
    end

    waveset_segmenter_rms u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .sample     (sample),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .start_pos  (start_pos),
        .end_pos    (end_pos),
        .rms        (rms)
    );

    waveset_span_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .sample     (sample),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .start_pos  (start_pos),
        .end_pos    (end_pos),
        .rms        (rms),
        .mismatches (mismatches),
        .spans_due  (spans_due)
    );

    function int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    function logic [15:0] pick_nonpos();
        int r;
        int m;
        r = $urandom_range(0, 15);
        m = $urandom_range(0, 32768);
        case (r)
            0:       return 16'h8000;
            1:       return 16'h0000;
            2:       return 16'hFFFF;
            default: return 16'(-m);
        endcase
    endfunction

    function logic [15:0] pick_pos();
        int r;
        r = $urandom_range(0, 15);
        case (r)
            0:       return 16'h7FFF;
            1:       return 16'h0001;
            default: return 16'($urandom_range(1, 32767));
        endcase
    endfunction

    task send_sample(input logic [15:0] s);
        int gap;
        gap = quiet ? 0 : gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= s;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (spans_due != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task write_min_length(input logic [LEN_BITS-1:0] v);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        cur_min      = int'(v);
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task send_burst(input int items);
        int sent;
        int target;
        int lows;
        int highs;
        int n;
        sent = 0;
        while (sent < items)
        begin
            if ($urandom_range(0, 7) == 0)
                quiet = ~quiet;
            if ($urandom_range(0, 9) < 8)
            begin
                target = $urandom_range(2, cur_min > 40 ? 80 : 2 * cur_min + 4);
                lows   = $urandom_range(1, target - 1);
                highs  = $urandom_range(1, target - lows);
                repeat (lows) send_sample(pick_nonpos());
                repeat (highs) send_sample(pick_pos());
                sent += lows + highs;
            end
            else
            begin
                n = $urandom_range(1, 8);
                repeat (n) send_sample(16'($urandom));
                sent += n;
            end
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        int hold;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (quiet)
                out_ready <= 1'b1;
            else if (hold == 0)
            begin
                out_ready <= ($urandom_range(0, 9) < 7);
                hold = gap_len();
            end
            else
                hold--;
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening[i])
            send_sample(opening[i]);

        write_min_length(24'd3);
        foreach (growing[i])
            send_sample(growing[i]);

        // hold one full-scale span open back to back
        quiet = 1'b1;
        repeat (LONG_RUN) send_sample(16'h8000);
        send_sample(16'h7FFF);
        quiet = 1'b0;

        foreach (phase_min[i])
        begin
            write_min_length(phase_min[i]);
            send_burst(BURST_ITEMS);
        end

        wait_idle();
        if (mismatches == 0 && spans_due == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== waveset_segmenter_rms.f =====
rtl/core/wss_pkg.sv
rtl/core/wss_front.sv
rtl/core/wss_queue.sv
rtl/core/wss_back.sv
rtl/core/waveset_segmenter_rms.sv
rtl/core/wss_checker.sv
dv/waveset_span_checker.sv
dv/testbench.sv
